// ----- rtl/esd_pkg.sv -----
// Shared types and constants for the escape sequence decoder.
// No dependencies; imported by every module of the block.
package esd_pkg;

  localparam int ESD_QDEPTH = 4;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_A_LC      = 8'h61;
  localparam logic [7:0] CH_B_LC      = 8'h62;
  localparam logic [7:0] CH_E_LC      = 8'h65;
  localparam logic [7:0] CH_F_LC      = 8'h66;
  localparam logic [7:0] CH_N_LC      = 8'h6E;
  localparam logic [7:0] CH_R_LC      = 8'h72;
  localparam logic [7:0] CH_T_LC      = 8'h74;
  localparam logic [7:0] CH_V_LC      = 8'h76;
  localparam logic [7:0] CH_X_LC      = 8'h78;

  localparam logic [7:0] CTL_BEL = 8'h07;
  localparam logic [7:0] CTL_BS  = 8'h08;
  localparam logic [7:0] CTL_ESC = 8'h1B;
  localparam logic [7:0] CTL_FF  = 8'h0C;
  localparam logic [7:0] CTL_LF  = 8'h0A;
  localparam logic [7:0] CTL_CR  = 8'h0D;
  localparam logic [7:0] CTL_HT  = 8'h09;
  localparam logic [7:0] CTL_VT  = 8'h0B;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] out_byte;
    logic       is_error;
    logic       is_last;
  } res_t;

endpackage

// ----- rtl/esd_step.sv -----
// Escape decoding state machine: holds mode, accumulator and digit count,
// and computes up to two result beats for the item at its input. Uses esd_pkg.
module esd_step (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_kind,
  input  logic [7:0]  item_byte,
  input  logic        fire,
  output logic [1:0]  res_cnt,
  output esd_pkg::res_t res0,
  output esd_pkg::res_t res1
);
  import esd_pkg::*;

  typedef enum logic [2:0] {
    M_NORMAL = 3'd0,
    M_ESC    = 3'd1,
    M_HEX    = 3'd2,
    M_OCT    = 3'd3,
    M_DROP   = 3'd4
  } mode_t;

  mode_t      mode_r, mode_nxt;
  logic [7:0] acc_r, acc_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  logic       hex_ok;
  logic [3:0] hex_val;
  logic       oct_ok;
  logic [2:0] oct_val;
  logic [7:0] hex_acc;
  logic [7:0] oct_acc;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    case (item_byte) inside
      [8'h30:8'h39]: hex_val = item_byte[3:0];
      [8'h41:8'h46],
      [8'h61:8'h66]: hex_val = item_byte[3:0] + 4'd9;
      default: hex_ok = 1'b0;
    endcase
  end

  assign oct_ok  = (item_byte[7:3] == 5'b00110);
  assign oct_val = item_byte[2:0];
  assign hex_acc = {acc_r[3:0], hex_val};
  assign oct_acc = {acc_r[4:0], oct_val};

  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    res_cnt  = 2'd0;
    res0     = '0;
    res1     = '0;
    if (item_kind) begin
      res_cnt       = 2'd1;
      res0.is_last  = 1'b1;
      case (mode_r)
        M_ESC, M_DROP: res0.is_error = 1'b1;
        M_HEX: begin
          if (cnt_r == 2'd0) begin
            res0.is_error = 1'b1;
          end else begin
            res0.has_byte = 1'b1;
            res0.out_byte = acc_r;
          end
        end
        M_OCT: begin
          res0.has_byte = 1'b1;
          res0.out_byte = acc_r;
        end
        default: ;
      endcase
      mode_nxt = M_NORMAL;
      acc_nxt  = '0;
      cnt_nxt  = '0;
    end else begin
      case (mode_r)
        M_ESC: begin
          mode_nxt      = M_NORMAL;
          res_cnt       = 2'd1;
          res0.has_byte = 1'b1;
          case (item_byte)
            CH_A_LC:      res0.out_byte = CTL_BEL;
            CH_B_LC:      res0.out_byte = CTL_BS;
            CH_E_LC:      res0.out_byte = CTL_ESC;
            CH_F_LC:      res0.out_byte = CTL_FF;
            CH_N_LC:      res0.out_byte = CTL_LF;
            CH_R_LC:      res0.out_byte = CTL_CR;
            CH_T_LC:      res0.out_byte = CTL_HT;
            CH_V_LC:      res0.out_byte = CTL_VT;
            CH_BACKSLASH: res0.out_byte = CH_BACKSLASH;
            CH_X_LC: begin
              res_cnt  = 2'd0;
              res0     = '0;
              mode_nxt = M_HEX;
              acc_nxt  = '0;
              cnt_nxt  = '0;
            end
            default: begin
              res0 = '0;
              if (oct_ok) begin
                res_cnt  = 2'd0;
                mode_nxt = M_OCT;
                acc_nxt  = {5'd0, oct_val};
                cnt_nxt  = 2'd1;
              end else begin
                res0.is_error = 1'b1;
                mode_nxt      = M_DROP;
                acc_nxt       = '0;
                cnt_nxt       = '0;
              end
            end
          endcase
        end
        M_HEX: begin
          if (hex_ok) begin
            if (cnt_r == 2'd1) begin
              res_cnt       = 2'd1;
              res0.has_byte = 1'b1;
              res0.out_byte = hex_acc;
              mode_nxt      = M_NORMAL;
              acc_nxt       = '0;
              cnt_nxt       = '0;
            end else begin
              acc_nxt = hex_acc;
              cnt_nxt = 2'd1;
            end
          end else if (cnt_r == 2'd0) begin
            res_cnt       = 2'd1;
            res0.is_error = 1'b1;
            mode_nxt      = M_DROP;
            acc_nxt       = '0;
            cnt_nxt       = '0;
          end else begin
            res_cnt       = 2'd1;
            res0.has_byte = 1'b1;
            res0.out_byte = acc_r;
            acc_nxt       = '0;
            cnt_nxt       = '0;
            if (item_byte == CH_BACKSLASH) begin
              mode_nxt = M_ESC;
            end else begin
              mode_nxt      = M_NORMAL;
              res_cnt       = 2'd2;
              res1.has_byte = 1'b1;
              res1.out_byte = item_byte;
            end
          end
        end
        M_OCT: begin
          if (oct_ok) begin
            if (cnt_r == 2'd2) begin
              res_cnt       = 2'd1;
              res0.has_byte = 1'b1;
              res0.out_byte = oct_acc;
              mode_nxt      = M_NORMAL;
              acc_nxt       = '0;
              cnt_nxt       = '0;
            end else begin
              acc_nxt = oct_acc;
              cnt_nxt = cnt_r + 2'd1;
            end
          end else begin
            res_cnt       = 2'd1;
            res0.has_byte = 1'b1;
            res0.out_byte = acc_r;
            acc_nxt       = '0;
            cnt_nxt       = '0;
            if (item_byte == CH_BACKSLASH) begin
              mode_nxt = M_ESC;
            end else begin
              mode_nxt      = M_NORMAL;
              res_cnt       = 2'd2;
              res1.has_byte = 1'b1;
              res1.out_byte = item_byte;
            end
          end
        end
        M_DROP: ;
        default: begin
          mode_nxt = M_NORMAL;
          if (item_byte == CH_BACKSLASH) begin
            mode_nxt = M_ESC;
          end else begin
            res_cnt       = 2'd1;
            res0.has_byte = 1'b1;
            res0.out_byte = item_byte;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_NORMAL;
      acc_r  <= '0;
      cnt_r  <= '0;
    end else if (fire) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item_kind |=> mode_r == M_NORMAL && acc_r == 8'd0 && cnt_r == 2'd0)
    else $error("end beat did not return decoder to reset state");

  a_last_single: assert property (@(posedge clk) disable iff (!rst_n)
    item_kind |-> res_cnt == 2'd1 && res0.is_last)
    else $error("end beat must give exactly one last result");

  a_digit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == M_HEX |-> cnt_r <= 2'd1) and (mode_r == M_OCT |-> cnt_r != 2'd0))
    else $error("digit count out of range for mode");

endmodule

// ----- rtl/esd_outq.sv -----
// Result queue: takes up to two result beats per cycle, delivers one per
// cycle on the output stream while pop is high. Uses esd_pkg.
module esd_outq #(
  parameter int DEPTH = esd_pkg::ESD_QDEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [1:0]  push_cnt,
  input  esd_pkg::res_t push0,
  input  esd_pkg::res_t push1,
  input  logic        pop,
  output logic        head_vld,
  output esd_pkg::res_t head,
  output logic [$clog2(DEPTH+1)-1:0] level
);
  import esd_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);

  res_t          q_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, wp1, rp_r, rp_nxt;
  logic [LW-1:0] cnt_r, cnt_nxt;

  assign wp1      = (wp_r == LAST_IDX) ? '0 : wp_r + PW'(1);
  assign head_vld = (cnt_r != '0);
  assign head     = q_r[rp_r];
  assign level    = cnt_r;

  always_comb begin
    wp_nxt = wp_r;
    if (push_cnt == 2'd1) begin
      wp_nxt = wp1;
    end else if (push_cnt == 2'd2) begin
      wp_nxt = (wp1 == LAST_IDX) ? '0 : wp1 + PW'(1);
    end
    rp_nxt = rp_r;
    if (pop) begin
      rp_nxt = (rp_r == LAST_IDX) ? '0 : rp_r + PW'(1);
    end
    cnt_nxt = cnt_r + LW'(push_cnt) - LW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      q_r[wp_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      q_r[wp1] <= push1;
    end
  end

endmodule

// ----- rtl/escape_sequence_decoder.sv -----
// Top level of the escape sequence decoder: input register, decoding state
// machine (esd_step) and result queue (esd_outq). Uses esd_pkg.
//
// Input stream: one character per beat in in_tdata; a beat with in_tlast
// high is the end of a string and its in_tdata is ignored. Output stream:
// out_tdata carries the decoded byte, out_tuser[0] says it is valid,
// out_tuser[1] flags a malformed or truncated escape, out_tlast marks the
// single result of an end beat. A backslash, the x of a hex escape and leading
// digits give no beat; a digit run ended by a plain character gives two beats.
// Path: a taken input beat is held in the input register, then its results are
// registered in the queue once they fit, and they leave from its head.
// Throughput: one input beat per cycle while the queue has room; the queue
// drains one result per cycle while out_tready is high, so a two-result item
// can hold input back when the queue runs full. in_tready drops while the
// input register holds an item whose results do not fit in the queue.
// Reset (rst_n low, synchronous) empties the queue and input register and
// returns the decoder to plain passthrough. When out_tready is low, results
// wait in the queue and input stalls once it fills.
module escape_sequence_decoder #(
  parameter int QDEPTH = esd_pkg::ESD_QDEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // kind: end of string
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [1:0] out_tuser,  // [0] has_byte, [1] is_error
  output logic       out_tlast   // is_last
);
  import esd_pkg::*;

  localparam int LW = $clog2(QDEPTH + 1);

  logic          vld_r;
  logic          kind_r;
  logic [7:0]    byte_r;
  logic          fire;
  logic [1:0]    res_cnt;
  res_t          res0, res1;
  res_t          head;
  logic [LW-1:0] level;
  logic          pop;

  assign fire      = vld_r && ((LW + 1)'(level) + (LW + 1)'(res_cnt) <= (LW + 1)'(QDEPTH));
  assign in_tready = !vld_r || fire;
  assign pop       = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_tready) begin
      vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      kind_r <= in_tlast;
      byte_r <= in_tdata;
    end
  end

  esd_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_kind (kind_r),
    .item_byte (byte_r),
    .fire      (fire),
    .res_cnt   (res_cnt),
    .res0      (res0),
    .res1      (res1)
  );

  esd_outq #(
    .DEPTH (QDEPTH)
  ) u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_cnt (fire ? res_cnt : 2'd0),
    .push0    (res0),
    .push1    (res1),
    .pop      (pop),
    .head_vld (out_tvalid),
    .head     (head),
    .level    (level)
  );

  assign out_tdata = head.out_byte;
  assign out_tuser = {head.is_error, head.has_byte};
  assign out_tlast = head.is_last;

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level <= LW'(QDEPTH))
    else $error("result queue overflow");

  a_fire_hold: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && !fire |=> vld_r && $stable(kind_r) && $stable(byte_r))
    else $error("pending beat lost while blocked");

  a_empty_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    level == LW'(1) && pop && !fire |=> !out_tvalid)
    else $error("queue shows a beat after draining");

endmodule
